FILE: rtl/core/xtea_block_cipher_core_defines.svh
// Assertion macros used by the checker file of the cipher core.
`ifndef XTEA_BLOCK_CIPHER_CORE_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XTEA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xtea checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define XTEA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xtea checker: next-cycle property failed");

`endif

FILE: rtl/core/xtea_pkg.sv
package xtea_pkg;

    // Number of half-rounds; an odd count is rounded down to whole rounds.
    localparam int HALF_ROUNDS = 64;
    localparam int FULL_ROUNDS = HALF_ROUNDS / 2;
    localparam int ROUND_W     = (FULL_ROUNDS > 1) ? $clog2(FULL_ROUNDS) : 1;
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(FULL_ROUNDS - 1);

    localparam int WORD_W = 32;
    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;
    // Starting sum for decryption: delta times the round count, modulo 2^32.
    localparam logic [63:0] DEC_SUM_WIDE = 64'(DELTA) * 64'(FULL_ROUNDS);
    localparam logic [WORD_W-1:0] DEC_SUM_INIT = DEC_SUM_WIDE[WORD_W-1:0];

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_ZERO  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_ONE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_TWO   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_THREE = 2'd3;

    // Command codes.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [3:0][WORD_W-1:0] key_array_t;

    // Working state of one block between rounds.
    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] sum;
    } round_state_t;

endpackage

FILE: rtl/core/xtea_round.sv
module xtea_round (
    input  xtea_pkg::round_state_t cur,
    input  logic                   decrypt,
    input  xtea_pkg::key_array_t   keys,
    output xtea_pkg::round_state_t nxt
);
    import xtea_pkg::*;

    function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    logic [WORD_W-1:0] sum_lo;
    logic [WORD_W-1:0] sum_hi;
    logic [WORD_W-1:0] key_lo;
    logic [WORD_W-1:0] key_hi;
    logic [WORD_W-1:0] enc_v0;
    logic [WORD_W-1:0] dec_v1;

    // The first half-round of a round uses the lower sum, the second the
    // sum one delta higher; decryption walks the same pair downwards.
    assign sum_lo = decrypt ? (cur.sum - DELTA) : cur.sum;
    assign sum_hi = decrypt ? cur.sum : (cur.sum + DELTA);
    assign key_lo = sum_lo + keys[sum_lo[1:0]];
    assign key_hi = sum_hi + keys[sum_hi[12:11]];

    assign enc_v0 = cur.v0 + (mix(cur.v1) ^ key_lo);
    assign dec_v1 = cur.v1 - (mix(cur.v0) ^ key_hi);

    always_comb
    begin
        if (decrypt)
        begin
            nxt.v1  = dec_v1;
            nxt.v0  = cur.v0 - (mix(dec_v1) ^ key_lo);
            nxt.sum = sum_lo;
        end
        else
        begin
            nxt.v0  = enc_v0;
            nxt.v1  = cur.v1 + (mix(enc_v0) ^ key_hi);
            nxt.sum = sum_hi;
        end
    end

endmodule

FILE: rtl/core/xtea_block_cipher_core.sv
// Channel   Handshake             Payload
// input     in_valid / in_ready   command, first_word, second_word, last_block
// output    out_valid / out_ready out_first_word, out_second_word, out_last_block
// config    cfg_valid / cfg_ready cfg_index, cfg_data (key words zero to three)
//
// A word is taken and then runs 32 rounds, one full round (two half-rounds)
// per clock through the single round unit; the next input word is only taken
// once the previous one has left the round unit after its last round.
// The result sits in an output register, so a new word is taken while an old
// result still waits; only the last round stalls when that register is full.
// Reset clears the control state and the four key words; cfg_ready is always high.
module xtea_block_cipher_core (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [31:0]                         first_word,
    input  logic [31:0]                         second_word,
    input  logic                                last_block,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [31:0]                         out_first_word,
    output logic [31:0]                         out_second_word,
    output logic                                out_last_block,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [xtea_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                         cfg_data
);
    import xtea_pkg::*;

    // Sequencer states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic               state_reg;
    logic               state_next;
    logic [ROUND_W-1:0] round_reg;
    logic [ROUND_W-1:0] round_next;
    round_state_t       work_reg;
    round_state_t       work_next;
    round_state_t       round_out;
    logic               decrypt_reg;
    logic               decrypt_next;
    logic               last_reg;
    logic               last_next;
    key_array_t         key_reg;
    key_array_t         key_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [WORD_W-1:0]  out_v0_reg;
    logic [WORD_W-1:0]  out_v0_next;
    logic [WORD_W-1:0]  out_v1_reg;
    logic [WORD_W-1:0]  out_v1_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic               in_take;
    logic               final_round;
    logic               out_free;
    logic               advance;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = in_valid && in_ready;

    // The output register can take a new result when it is empty or being read.
    assign out_free    = !out_valid_reg || out_ready;
    assign final_round = (round_reg == LAST_ROUND);
    assign advance     = (state_reg == ST_RUN) && (!final_round || out_free);

    xtea_round u_round (
        .cur     (work_reg),
        .decrypt (decrypt_reg),
        .keys    (key_reg),
        .nxt     (round_out)
    );

    // Key registers: a write takes effect at once, even in the middle of a
    // block, so the key is only to be changed while the core is idle.
    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KEY_ZERO:  key_next[0] = cfg_data;
                CFG_KEY_ONE:   key_next[1] = cfg_data;
                CFG_KEY_TWO:   key_next[2] = cfg_data;
                CFG_KEY_THREE: key_next[3] = cfg_data;
                default:       key_next    = key_reg;
            endcase
        end
    end

    // Round sequencer: load on acceptance, one round per cycle, and a hold on
    // the last round while the previous result has not yet been taken.
    always_comb
    begin
        state_next   = state_reg;
        round_next   = round_reg;
        work_next    = work_reg;
        decrypt_next = decrypt_reg;
        last_next    = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next   = ST_RUN;
                    round_next   = '0;
                    work_next.v0 = first_word;
                    work_next.v1 = second_word;
                    work_next.sum = (command == CMD_DECRYPT) ? DEC_SUM_INIT : '0;
                    decrypt_next = (command == CMD_DECRYPT);
                    last_next    = last_block;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    work_next  = round_out;
                    round_next = round_reg + ROUND_W'(1);
                    if (final_round)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_v0_next    = out_v0_reg;
        out_v1_next    = out_v1_reg;
        out_last_next  = out_last_reg;
        if (advance && final_round)
        begin
            out_valid_next = 1'b1;
            out_v0_next    = round_out.v0;
            out_v1_next    = round_out.v1;
            out_last_next  = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
            key_reg       <= key_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        decrypt_reg  <= decrypt_next;
        last_reg     <= last_next;
        out_v0_reg   <= out_v0_next;
        out_v1_reg   <= out_v1_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_first_word  = out_v0_reg;
    assign out_second_word = out_v1_reg;
    assign out_last_block  = out_last_reg;

endmodule

FILE: rtl/core/xtea_checker.sv
`include "xtea_block_cipher_core_defines.svh"

module xtea_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_first_word,
    input logic [31:0] out_second_word,
    input logic        out_last_block
);

    // A stalled result stays offered.
    `XTEA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // A stalled result keeps its value.
    `XTEA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(out_first_word) && $stable(out_second_word) && $stable(out_last_block))

    // Once a word is taken, the core is busy with its rounds.
    `XTEA_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

    // A new result only appears at the end of a run, while the core was busy.
    `XTEA_ASSERT_SAME(a_result_from_run, $rose(out_valid), !$past(in_ready))

endmodule

bind xtea_block_cipher_core xtea_checker u_xtea_checker (.*);

FILE: tb/xtea_block_cipher_core_test.sv
`timescale 1ns / 100ps

module xtea_block_cipher_core_test;

    import xtea_pkg::*;

    // One transformed block as it leaves the core.
    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic        last_flag;
    } cipher_block_t;

    logic        clk;
    logic        rst_n;

    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic        last_block;

    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_first_word;
    logic [31:0] out_second_word;
    logic        out_last_block;

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    // The predictor's own copy of the 128-bit key, updated on every accepted
    // configuration word.
    logic [31:0] cipher_key [4];

    // Blocks still owed by the core, oldest first.
    cipher_block_t pending_blocks [$];

    int unsigned error_count;

    // Idling controls: the sender may leave gaps between words, and the
    // receiver may hold out_ready low for a while.
    bit          sender_gaps_on;
    bit          out_stalls_on;
    int unsigned out_stall_left;

    xtea_block_cipher_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .first_word      (first_word),
        .second_word     (second_word),
        .last_block      (last_block),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_first_word  (out_first_word),
        .out_second_word (out_second_word),
        .out_last_block  (out_last_block),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // The XTEA mixing function applied to one half of the block before the
    // subkey is folded in.
    function automatic logic [31:0] feistel_mix(logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    // Predicts the block that the core must return for one input word, under
    // the key held at the moment the word is accepted.
    function automatic cipher_block_t cipher_block(logic cmd, logic [31:0] w0,
                                                   logic [31:0] w1, logic last_in);
        logic [31:0]   a;
        logic [31:0]   b;
        logic [31:0]   sum;
        cipher_block_t res;
        a = w0;
        b = w1;
        if (cmd == CMD_ENCRYPT)
        begin
            sum = '0;
            for (int r = 0; r < FULL_ROUNDS; r++)
            begin
                a   = a + (feistel_mix(b) ^ (sum + cipher_key[sum[1:0]]));
                sum = sum + DELTA;
                b   = b + (feistel_mix(a) ^ (sum + cipher_key[sum[12:11]]));
            end
        end
        else
        begin
            // Decryption starts from delta times the round count, wrapped to
            // 32 bits, and walks the schedule backwards.
            sum = DELTA * 32'(FULL_ROUNDS);
            for (int r = 0; r < FULL_ROUNDS; r++)
            begin
                b   = b - (feistel_mix(a) ^ (sum + cipher_key[sum[12:11]]));
                sum = sum - DELTA;
                a   = a - (feistel_mix(b) ^ (sum + cipher_key[sum[1:0]]));
            end
        end
        res.w0        = a;
        res.w1        = b;
        res.last_flag = last_in;
        return res;
    endfunction

    // Idle lengths: half of them nothing, most of the rest a few cycles, and
    // about one in ten long enough to span several rounds of a block.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 70);
    endfunction

    // Data words lean towards the extremes now and then.
    function automatic logic [31:0] random_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        else if (r == 1)
            return 32'hFFFF_FFFF;
        else
            return $urandom;
    endfunction

    // Receiver: out_ready is assigned once per clock edge. With stalls
    // enabled it drops for a random number of cycles now and again.
    initial
    begin
        out_ready      = 1'b0;
        out_stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (!out_stalls_on)
            begin
                out_ready <= 1'b1;
            end
            else if (out_stall_left > 0)
            begin
                out_ready <= 1'b0;
                out_stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    out_stall_left = idle_length();
            end
        end
    end

    // Result checker: each word taken from the output channel is compared with
    // the oldest block still owed. Values are read straight after the edge, so
    // they are the ones that the edge itself sampled.
    always @(posedge clk)
    begin
        cipher_block_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_blocks.size() == 0)
            begin
                $error("unexpected output word: %h %h last %b",
                       out_first_word, out_second_word, out_last_block);
                error_count++;
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (out_first_word !== want.w0)
                begin
                    $error("out_first_word: expected %h, actual %h",
                           want.w0, out_first_word);
                    error_count++;
                end
                if (out_second_word !== want.w1)
                begin
                    $error("out_second_word: expected %h, actual %h",
                           want.w1, out_second_word);
                    error_count++;
                end
                if (out_last_block !== want.last_flag)
                begin
                    $error("out_last_block: expected %b, actual %b",
                           want.last_flag, out_last_block);
                    error_count++;
                end
            end
        end
    end

    // Offers one block on the input channel and records its prediction once
    // the core accepts it. A gap, if any, lowers valid first; otherwise valid
    // simply stays high from the previous word, so it is never lowered and
    // raised within the same edge.
    task automatic send_block(logic cmd, logic [31:0] w0, logic [31:0] w1,
                              logic last_in);
        int unsigned gap;
        gap = sender_gaps_on ? idle_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        first_word  <= w0;
        second_word <= w1;
        last_block  <= last_in;
        do
            @(posedge clk);
        while (!in_ready);
        pending_blocks.push_back(cipher_block(cmd, w0, w1, last_in));
    endtask

    // Stops sending and waits until every owed block has come back. Each block
    // gives exactly one result, so the core is idle once the queue is empty;
    // a few spare cycles are allowed all the same.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one key word. Valid is left high so that a following write can
    // keep it up; load_key lowers it after the last word.
    task automatic write_key_word(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cipher_key[idx] = data;
    endtask

    // Loads the full key while the core is idle.
    task automatic load_key(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                            logic [31:0] k3);
        wait_for_results();
        write_key_word(CFG_KEY_ZERO,  k0);
        write_key_word(CFG_KEY_ONE,   k1);
        write_key_word(CFG_KEY_TWO,   k2);
        write_key_word(CFG_KEY_THREE, k3);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // The key is all zero after reset, so both directions must work on it
    // before any key word has been written.
    task automatic test_reset_key();
        send_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    endtask

    // Field and key extremes: an all-ones key, then two alternating bit patterns,
    // all zeros and all ones, so that every key word selects a visibly different value.
    task automatic test_key_extremes();
        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_block(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0);
        send_block(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b1);
        load_key(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 32'hFFFF_FFFF);
        send_block(CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        send_block(CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    endtask

    // Decryption of a ciphertext must give the plaintext back: each block is
    // encrypted and its predicted ciphertext is then decrypted.
    task automatic test_round_trip();
        cipher_block_t ct;
        logic [31:0]   p0;
        logic [31:0]   p1;
        load_key($urandom, $urandom, $urandom, $urandom);
        repeat (3)
        begin
            p0 = $urandom;
            p1 = $urandom;
            ct = cipher_block(CMD_ENCRYPT, p0, p1, 1'b0);
            send_block(CMD_ENCRYPT, p0, p1, 1'b0);
            send_block(CMD_DECRYPT, ct.w0, ct.w1, 1'b1);
            if (cipher_block(CMD_DECRYPT, ct.w0, ct.w1, 1'b1) !== {p0, p1, 1'b1})
            begin
                $error("round trip: predictor does not invert block %h %h", p0, p1);
                error_count++;
            end
        end
    endtask

    // Full rate: words offered back to back and the output always ready, so
    // the core runs at its own pace with no idling on either side.
    task automatic test_back_to_back(int unsigned count);
        sender_gaps_on = 1'b0;
        out_stalls_on  = 1'b0;
        load_key($urandom, $urandom, $urandom, $urandom);
        repeat (count)
            send_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT,
                       $urandom, $urandom, 1'($urandom_range(0, 1)));
        sender_gaps_on = 1'b1;
        out_stalls_on  = 1'b1;
    endtask

    // Random blocks in phases, each under a fresh key. Now and then the
    // sender holds off until everything owed has come back.
    task automatic test_random_traffic(int unsigned phases, int unsigned per_phase);
        for (int unsigned p = 0; p < phases; p++)
        begin
            case (p % 5)
                1: load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: load_key(32'h0000_0000, $urandom, 32'h0000_0000, 32'h0000_0000);
                4: load_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
                default: load_key($urandom, $urandom, $urandom, $urandom);
            endcase
            repeat (per_phase)
            begin
                if ($urandom_range(0, 49) == 0)
                    wait_for_results();
                send_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT,
                           random_word(), random_word(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Main sequence: reset once, then the tests in turn, then the verdict.
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_ENCRYPT;
        first_word     = '0;
        second_word    = '0;
        last_block     = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_KEY_ZERO;
        cfg_data       = '0;
        error_count    = 0;
        sender_gaps_on = 1'b1;
        out_stalls_on  = 1'b1;
        for (int i = 0; i < 4; i++)
            cipher_key[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_key();
        test_key_extremes();
        test_round_trip();
        test_back_to_back(100);
        test_random_traffic(5, 130);

        // Everything sent: wait for the last results, then leave room for any
        // stray word the core might still produce.
        wait_for_results();
        repeat (40) @(posedge clk);

        if (error_count == 0)
            $display("xtea_block_cipher_core_test: done, clean");
        else
            $display("xtea_block_cipher_core_test: done, errors");
        $finish;
    end

    // Watchdog: a run that hangs on a handshake ends here as a failure.
    initial
    begin
        #2_000_000;
        $display("xtea_block_cipher_core_test: done, errors");
        $finish;
    end

endmodule

FILE: xtea_block_cipher_core.f
+incdir+rtl/core
rtl/core/xtea_pkg.sv
rtl/core/xtea_round.sv
rtl/core/xtea_block_cipher_core.sv
rtl/core/xtea_checker.sv
tb/xtea_block_cipher_core_test.sv
